FILE: hdl/mbps_pkg.sv
// Shared constants, types and codes for the masked byte pattern scanner.
`default_nettype none

package mbps_pkg;

	localparam int MAX_PATTERN_BYTES = 16;
	localparam int HIT_COUNT_BITS = 16;

	localparam int ADDR_W = 64;
	localparam int CFG_W = 64;
	localparam int CFG_IDX_W = 3;
	localparam int LEN_W = 5;
	localparam int FIELD16_W = 16;
	localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
	localparam int CMP_W = (HIT_COUNT_BITS > FIELD16_W) ? HIT_COUNT_BITS : FIELD16_W;
	localparam int MOD_STEP_W = $clog2(ADDR_W);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PATTERN_LOW  = 3'd0,
		CFG_PATTERN_HIGH = 3'd1,
		CFG_MASK_LOW     = 3'd2,
		CFG_MASK_HIGH    = 3'd3,
		CFG_LENGTH       = 3'd4,
		CFG_ALIGNMENT    = 3'd5,
		CFG_HIT_LIMIT    = 3'd6,
		CFG_CAPACITY     = 3'd7
	} cfg_reg_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_MOD  = 1'b1
	} scan_state_t;

	typedef enum logic {
		KIND_MATCH    = 1'b0,
		KIND_OVERFLOW = 1'b1
	} hit_kind_t;

	typedef struct packed {
		logic                 busy;
		logic [FIELD16_W-1:0] remainder;
	} mod_status_t;

endpackage

`default_nettype wire

FILE: hdl/mbps_mod_unit.sv
// Bit-serial remainder unit: address modulo start alignment, one dividend bit per cycle.
`default_nettype none

module mbps_mod_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic [mbps_pkg::ADDR_W-1:0]      dividend,
	input  wire logic [mbps_pkg::FIELD16_W-1:0]   divisor,
	output mbps_pkg::mod_status_t                 status
);

	logic                              busy_q;
	logic [mbps_pkg::MOD_STEP_W-1:0]   step_q;
	logic [mbps_pkg::FIELD16_W-1:0]    rem_q;
	logic [mbps_pkg::FIELD16_W-1:0]    div_q;
	logic [mbps_pkg::ADDR_W-1:0]       shift_q;
	logic [mbps_pkg::FIELD16_W:0]      trial;
	logic [mbps_pkg::FIELD16_W:0]      diff;

	assign trial = {rem_q, shift_q[mbps_pkg::ADDR_W-1]};
	assign diff = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= mbps_pkg::MOD_STEP_W'(mbps_pkg::ADDR_W - 1);
		end else if (busy_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			shift_q <= dividend;
		end else if (busy_q) begin
			// The partial remainder stays below the divisor, so it fits in 16 bits.
			if (trial >= {1'b0, div_q}) begin
				rem_q <= diff[mbps_pkg::FIELD16_W-1:0];
			end else begin
				rem_q <= trial[mbps_pkg::FIELD16_W-1:0];
			end
			shift_q <= {shift_q[mbps_pkg::ADDR_W-2:0], 1'b0};
		end
	end

	assign status.busy = busy_q;
	assign status.remainder = rem_q;

endmodule

`default_nettype wire

FILE: hdl/mbps_cell.sv
// One window cell: holds a byte and its alignment mark and compares the incoming byte.
`default_nettype none

module mbps_cell (
	input  wire logic                                          clk,
	input  wire logic                                          arst_n,
	input  wire logic                                          shift_en,
	input  wire logic [7:0]                                    byte_in,
	input  wire logic                                          mark_in,
	input  wire logic [8*mbps_pkg::MAX_PATTERN_BYTES-1:0]      pattern,
	input  wire logic [8*mbps_pkg::MAX_PATTERN_BYTES-1:0]      mask,
	input  wire logic [mbps_pkg::IDX_W-1:0]                    sel,
	input  wire logic                                          in_use,
	output logic [7:0]                                         byte_out,
	output logic                                               mark_out,
	output logic                                               match_ok
);

	logic [7:0] byte_q;
	logic       mark_q;
	logic [7:0] pat_byte;
	logic [7:0] mask_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
			mark_q <= 1'b0;
		end else if (shift_en) begin
			byte_q <= byte_in;
			mark_q <= mark_in;
		end
	end

	assign pat_byte = pattern[8*sel +: 8];
	assign mask_byte = mask[8*sel +: 8];

	// The compare looks at the byte this cell takes at the coming shift.
	assign match_ok = !in_use || ((byte_in & mask_byte) == (pat_byte & mask_byte));

	assign byte_out = byte_q;
	assign mark_out = mark_q;

endmodule

`default_nettype wire

FILE: hdl/masked_byte_pattern_scan.sv
// A byte inside a run gives its result in the output register in the cycle after acceptance.
// A byte that starts a run (new_run or new_scan) first runs the serial remainder unit; its result
// is registered once the unit is done and the output register is free, and can be taken at the
// same edge at which the next item can be accepted. A result that waits in the output register
// holds off the input. Throughput: one item per cycle inside a run while results are taken.
// Reset clears the window cells, phase, hit count, stop flag and output valid, and loads
// the register reset values.
`default_nettype none

module masked_byte_pattern_scan (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_write,
	input  wire logic [mbps_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [mbps_pkg::CFG_W-1:0]           cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic                                 new_scan,
	input  wire logic                                 new_run,
	input  wire logic [7:0]                           data_byte,
	input  wire logic [mbps_pkg::ADDR_W-1:0]          byte_address,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic [mbps_pkg::ADDR_W-1:0]               hit_start,
	output logic                                      hit_kind,
	output logic [mbps_pkg::FIELD16_W-1:0]            hit_index,
	output logic                                      scan_stopped
);

	localparam int NB = mbps_pkg::MAX_PATTERN_BYTES;

	// Configuration registers.
	logic [mbps_pkg::CFG_W-1:0]     pat_lo_q, pat_hi_q, mask_lo_q, mask_hi_q;
	logic [mbps_pkg::LEN_W-1:0]     len_q;
	logic [mbps_pkg::FIELD16_W-1:0] align_q, limit_q, cap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			mask_lo_q <= '0;
			mask_hi_q <= '0;
			len_q <= mbps_pkg::LEN_W'(1);
			align_q <= mbps_pkg::FIELD16_W'(1);
			limit_q <= '0;
			cap_q <= '1;
		end else if (cfg_write) begin
			case (mbps_pkg::cfg_reg_t'(cfg_index))
				mbps_pkg::CFG_PATTERN_LOW:  pat_lo_q <= cfg_data;
				mbps_pkg::CFG_PATTERN_HIGH: pat_hi_q <= cfg_data;
				mbps_pkg::CFG_MASK_LOW:     mask_lo_q <= cfg_data;
				mbps_pkg::CFG_MASK_HIGH:    mask_hi_q <= cfg_data;
				mbps_pkg::CFG_LENGTH:       len_q <= cfg_data[mbps_pkg::LEN_W-1:0];
				mbps_pkg::CFG_ALIGNMENT:    align_q <= cfg_data[mbps_pkg::FIELD16_W-1:0];
				mbps_pkg::CFG_HIT_LIMIT:    limit_q <= cfg_data[mbps_pkg::FIELD16_W-1:0];
				mbps_pkg::CFG_CAPACITY:     cap_q <= cfg_data[mbps_pkg::FIELD16_W-1:0];
				default: ;
			endcase
		end
	end

	logic [2*mbps_pkg::CFG_W-1:0]   pattern_all, mask_all;
	logic [mbps_pkg::LEN_W-1:0]     n_eff;
	logic [mbps_pkg::IDX_W-1:0]     last_idx;
	logic [mbps_pkg::FIELD16_W-1:0] align_eff, limit_eff;

	assign pattern_all = {pat_hi_q, pat_lo_q};
	assign mask_all = {mask_hi_q, mask_lo_q};
	assign align_eff = (align_q == '0) ? mbps_pkg::FIELD16_W'(1) : align_q;
	assign limit_eff = (limit_q == '0) ? cap_q : limit_q;

	always_comb begin
		if (len_q == '0) begin
			n_eff = mbps_pkg::LEN_W'(1);
		end else if (len_q > mbps_pkg::LEN_W'(NB)) begin
			n_eff = mbps_pkg::LEN_W'(NB);
		end else begin
			n_eff = len_q;
		end
	end

	assign last_idx = mbps_pkg::IDX_W'(n_eff - mbps_pkg::LEN_W'(1));

	// Control state.
	mbps_pkg::scan_state_t          state_q, state_d;
	mbps_pkg::mod_status_t          mod_st;
	logic [mbps_pkg::FIELD16_W-1:0] phase_q;
	logic [mbps_pkg::HIT_COUNT_BITS-1:0] cnt_q;
	logic                           stopped_q;
	logic [7:0]                     hold_data_q;
	logic [mbps_pkg::ADDR_W-1:0]    hold_addr_q;

	logic out_valid_q;
	logic out_free;
	logic accept;
	logic eff_stopped;
	logic run_start;
	logic start_mod;
	logic proc_direct;
	logic proc_held;
	logic do_proc;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == mbps_pkg::ST_IDLE) && out_free;
	assign accept = in_valid && in_ready;
	assign eff_stopped = stopped_q && !new_scan;
	assign run_start = new_scan || new_run;
	assign start_mod = accept && !eff_stopped && run_start;
	assign proc_direct = accept && !eff_stopped && !run_start;
	assign proc_held = (state_q == mbps_pkg::ST_MOD) && !mod_st.busy && out_free;
	assign do_proc = proc_direct || proc_held;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mbps_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			mbps_pkg::ST_IDLE: begin
				if (start_mod) begin
					state_d = mbps_pkg::ST_MOD;
				end
			end
			mbps_pkg::ST_MOD: begin
				if (proc_held) begin
					state_d = mbps_pkg::ST_IDLE;
				end
			end
			default: state_d = mbps_pkg::ST_IDLE;
		endcase
	end

	mbps_mod_unit u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_mod),
		.dividend (byte_address),
		.divisor  (align_eff),
		.status   (mod_st)
	);

	always_ff @(posedge clk) begin
		if (start_mod) begin
			hold_data_q <= data_byte;
			hold_addr_q <= byte_address;
		end
	end

	// Operands of the byte being processed this cycle.
	logic [7:0]                     p_data;
	logic [mbps_pkg::ADDR_W-1:0]    p_addr;
	logic [mbps_pkg::FIELD16_W-1:0] p_phase;
	logic                           p_clear;
	logic [mbps_pkg::FIELD16_W:0]   phase_inc;
	logic [mbps_pkg::FIELD16_W-1:0] phase_next;

	assign p_data = proc_held ? hold_data_q : data_byte;
	assign p_addr = proc_held ? hold_addr_q : byte_address;
	assign p_phase = proc_held ? mod_st.remainder : phase_q;
	assign p_clear = proc_held;
	assign phase_inc = {1'b0, p_phase} + 1'b1;
	assign phase_next = (phase_inc >= {1'b0, align_eff}) ? '0
		: phase_inc[mbps_pkg::FIELD16_W-1:0];

	// Window chain: cell 0 takes the new byte, each further cell its neighbor's contents (cleared at a run start).
	logic [7:0] in_byte  [NB];
	logic [7:0] cell_byte[NB];
	logic [NB-1:0] in_mark;
	logic [NB-1:0] cell_mark;
	logic [NB-1:0] cell_ok;

	for (genvar k = 0; k < NB; k++) begin : g_cell
		logic [mbps_pkg::IDX_W-1:0] sel;
		logic                       in_use;

		if (k == 0) begin : g_head
			assign in_byte[k] = p_data;
			assign in_mark[k] = (p_phase == '0);
		end else begin : g_body
			assign in_byte[k] = p_clear ? 8'h00 : cell_byte[k-1];
			assign in_mark[k] = p_clear ? 1'b0 : cell_mark[k-1];
		end

		// Cell k holds the byte that pattern position n-1-k is checked against.
		assign sel = mbps_pkg::IDX_W'(n_eff - mbps_pkg::LEN_W'(k) - mbps_pkg::LEN_W'(1));
		assign in_use = mbps_pkg::LEN_W'(k) < n_eff;

		mbps_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (do_proc),
			.byte_in  (in_byte[k]),
			.mark_in  (in_mark[k]),
			.pattern  (pattern_all[8*NB-1:0]),
			.mask     (mask_all[8*NB-1:0]),
			.sel      (sel),
			.in_use   (in_use),
			.byte_out (cell_byte[k]),
			.mark_out (cell_mark[k]),
			.match_ok (cell_ok[k])
		);
	end

	// A cleared cell carries no mark, so an unfilled window never reports a match.
	logic matched;
	assign matched = in_mark[last_idx] && (&cell_ok);

	// Hit accounting.
	logic [mbps_pkg::CMP_W-1:0]          cnt_ext, cnt_inc_ext, cap_ext, limit_ext;
	logic [mbps_pkg::HIT_COUNT_BITS-1:0] cnt_inc;
	logic                                overflow;
	logic                                limit_met;
	logic                                stop_after;

	assign cnt_inc = cnt_q + 1'b1;
	assign cnt_ext = mbps_pkg::CMP_W'(cnt_q);
	assign cnt_inc_ext = mbps_pkg::CMP_W'(cnt_inc);
	assign cap_ext = mbps_pkg::CMP_W'(cap_q);
	assign limit_ext = mbps_pkg::CMP_W'(limit_eff);
	assign overflow = ((cnt_ext >= cap_ext) && (cap_q < limit_eff)) || (&cnt_q);
	assign limit_met = cnt_ext >= limit_ext;
	assign stop_after = cnt_inc_ext >= limit_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			cnt_q <= '0;
			stopped_q <= 1'b0;
		end else begin
			if (accept && new_scan) begin
				cnt_q <= '0;
				stopped_q <= 1'b0;
			end
			if (do_proc) begin
				phase_q <= phase_next;
				if (matched) begin
					if (overflow || limit_met) begin
						stopped_q <= 1'b1;
					end else begin
						cnt_q <= cnt_inc;
						stopped_q <= stop_after;
					end
				end
			end
		end
	end

	// Output register.
	logic                           emit;
	logic [mbps_pkg::ADDR_W-1:0]    res_addr_q;
	logic                           res_kind_q;
	logic [mbps_pkg::FIELD16_W-1:0] res_index_q;
	logic                           res_stop_q;

	assign emit = do_proc && matched && (overflow || !limit_met);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (overflow) begin
				res_addr_q <= '0;
				res_kind_q <= mbps_pkg::KIND_OVERFLOW;
				res_index_q <= cnt_ext[mbps_pkg::FIELD16_W-1:0];
				res_stop_q <= 1'b1;
			end else begin
				res_addr_q <= p_addr - mbps_pkg::ADDR_W'(last_idx);
				res_kind_q <= mbps_pkg::KIND_MATCH;
				res_index_q <= cnt_inc_ext[mbps_pkg::FIELD16_W-1:0];
				res_stop_q <= stop_after;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign hit_start = res_addr_q;
	assign hit_kind = res_kind_q;
	assign hit_index = res_index_q;
	assign scan_stopped = res_stop_q;

endmodule

`default_nettype wire

FILE: hdl/mbps_checker.sv
// Port-level checks for the masked byte pattern scanner, bound to the top level.
`default_nettype none

module mbps_checker (
	input wire logic                                 clk,
	input wire logic                                 arst_n,
	input wire logic                                 in_ready,
	input wire logic                                 out_valid,
	input wire logic                                 out_ready,
	input wire logic [mbps_pkg::ADDR_W-1:0]          hit_start,
	input wire logic                                 hit_kind,
	input wire logic [mbps_pkg::FIELD16_W-1:0]       hit_index,
	input wire logic                                 scan_stopped
);

	// A waiting result keeps its contents until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit_start) && $stable(hit_index)
			&& $stable(hit_kind) && $stable(scan_stopped))
		else $error("result item changed while stalled");

	// An overflow item carries a zero address and always ends the scan.
	a_overflow_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (hit_kind == mbps_pkg::KIND_OVERFLOW) |-> (hit_start == '0) && scan_stopped)
		else $error("overflow item malformed");

	// A recorded match always counts at least itself.
	a_match_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (hit_kind == mbps_pkg::KIND_MATCH) |-> (hit_index != '0))
		else $error("match item with zero hit index");

	// No new item enters while a result is stalled in the output register.
	a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while result stalled");

endmodule

bind masked_byte_pattern_scan mbps_checker u_mbps_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.hit_start    (hit_start),
	.hit_kind     (hit_kind),
	.hit_index    (hit_index),
	.scan_stopped (scan_stopped)
);

`default_nettype wire

FILE: tb/masked_byte_pattern_scan_test.sv
// Self-checking testbench for the masked byte pattern scanner: directed table, then random runs.

module masked_byte_pattern_scan_test;

	import mbps_pkg::*;

	localparam int DRAIN_CYCLES = 80;
	localparam int unsigned COUNT_TOP = (1 << HIT_COUNT_BITS) - 1;
	localparam int RANDOM_BYTES = 580;
	localparam int MAX_PRINTED = 100;

	typedef enum logic [1:0] {
		CHK_PRED,
		CHK_NONE,
		CHK_HIT
	} check_t;

	typedef enum logic {
		ROW_ITEM,
		ROW_REG
	} row_kind_t;

	typedef struct packed {
		logic        new_scan;
		logic        new_run;
		logic [7:0]  data;
		logic [63:0] addr;
	} scan_in_t;

	typedef struct packed {
		logic [63:0] addr;
		hit_kind_t   kind;
		logic [15:0] index;
		logic        stopped;
	} scan_hit_t;

	typedef struct packed {
		logic [63:0] pat_lo;
		logic [63:0] pat_hi;
		logic [63:0] msk_lo;
		logic [63:0] msk_hi;
		logic [4:0]  plen;
		logic [15:0] align;
		logic [15:0] limit;
		logic [15:0] cap;
	} scan_cfg_t;

	typedef struct {
		row_kind_t   kind;
		cfg_reg_t    reg_id;
		logic [63:0] value;
		scan_in_t    item;
		check_t      chk;
		scan_hit_t   hit;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_write;
	cfg_reg_t cfg_index;
	logic [63:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic new_scan;
	logic new_run;
	logic [7:0] data_byte;
	logic [63:0] byte_address;
	logic out_valid;
	logic out_ready;
	logic [63:0] hit_start;
	logic hit_kind;
	logic [15:0] hit_index;
	logic scan_stopped;

	// Predictor copy of the registers and of the scan state.
	scan_cfg_t cfg_live = '{64'd0, 64'd0, 64'd0, 64'd0, 5'd1, 16'd1, 16'd0, 16'hFFFF};
	bit [7:0] win_bytes [MAX_PATTERN_BYTES];
	bit win_marks [MAX_PATTERN_BYTES];
	int unsigned win_fill;
	int unsigned phase_ctr;
	int unsigned hits_counted;
	bit scan_halted;

	scan_hit_t hits_due [$];
	plan_row_t directed_plan [$];
	int mismatches;
	int matches_seen;
	int overflows_seen;
	int bytes_sent;
	int scanned_random;
	int ignored_random;
	bit work_since_idle;
	bit calm;

	masked_byte_pattern_scan u_dut (.*);

	always #4 clk = ~clk;

	initial begin
		#10_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= MAX_PRINTED) begin
			$display("MISMATCH %0t: %s", $time, what);
		end
	endtask

	task automatic plan_add(input plan_row_t r);
		directed_plan.insert(directed_plan.size(), r);
	endtask

	function automatic logic [7:0] cfg_byte(logic [63:0] lo, logic [63:0] hi, int unsigned p);
		return (p < 8) ? lo[8*p +: 8] : hi[8*(p-8) +: 8];
	endfunction

	function automatic int unsigned eff_align();
		return (cfg_live.align == 0) ? 1 : cfg_live.align;
	endfunction

	function automatic int unsigned eff_len();
		if (cfg_live.plen == 0) begin
			return 1;
		end
		return (cfg_live.plen > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : cfg_live.plen;
	endfunction

	// Advances the scan state by one byte and gives the hit that the byte causes, if any.
	task automatic scan_predict(input scan_in_t it, output bit taken, output bit has_hit,
			output scan_hit_t h);
		int unsigned align_eff, len_eff, limit_eff, k;
		bit same;
		logic [7:0] m;
		align_eff = eff_align();
		len_eff = eff_len();
		limit_eff = (cfg_live.limit == 0) ? cfg_live.cap : cfg_live.limit;
		has_hit = 1'b0;
		h = '0;
		if (it.new_scan) begin
			hits_counted = 0;
			scan_halted = 1'b0;
		end
		taken = !scan_halted;
		if (scan_halted) begin
			return;
		end
		if (it.new_scan || it.new_run) begin
			for (k = 0; k < MAX_PATTERN_BYTES; k++) begin
				win_bytes[k] = 8'h00;
				win_marks[k] = 1'b0;
			end
			win_fill = 0;
			phase_ctr = int'(it.addr % 64'(align_eff));
		end
		for (k = MAX_PATTERN_BYTES - 1; k > 0; k--) begin
			win_bytes[k] = win_bytes[k-1];
			win_marks[k] = win_marks[k-1];
		end
		win_bytes[0] = it.data;
		win_marks[0] = (phase_ctr == 0);
		if (win_fill < MAX_PATTERN_BYTES) begin
			win_fill++;
		end
		phase_ctr = (phase_ctr + 1 >= align_eff) ? 0 : phase_ctr + 1;
		// The oldest byte of the window must sit on an aligned start address.
		if (win_fill < len_eff || !win_marks[len_eff-1]) begin
			return;
		end
		same = 1'b1;
		for (k = 0; k < len_eff; k++) begin
			m = cfg_byte(cfg_live.msk_lo, cfg_live.msk_hi, k);
			if ((win_bytes[len_eff-1-k] & m) != (cfg_byte(cfg_live.pat_lo, cfg_live.pat_hi, k) & m)) begin
				same = 1'b0;
			end
		end
		if (!same) begin
			return;
		end
		if ((hits_counted >= cfg_live.cap && cfg_live.cap < limit_eff) || hits_counted >= COUNT_TOP) begin
			scan_halted = 1'b1;
			has_hit = 1'b1;
			h = '{64'd0, KIND_OVERFLOW, 16'(hits_counted), 1'b1};
			return;
		end
		if (hits_counted >= limit_eff) begin
			scan_halted = 1'b1;
			return;
		end
		hits_counted++;
		if (hits_counted >= limit_eff) begin
			scan_halted = 1'b1;
		end
		has_hit = 1'b1;
		h = '{it.addr - 64'(len_eff - 1), KIND_MATCH, 16'(hits_counted), scan_halted};
	endtask

	function automatic int pick_gap();
		int r;
		if (calm) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	task automatic send_item(input scan_in_t it, input check_t chk, input scan_hit_t typed,
			output bit taken);
		int gap;
		bit has_hit;
		scan_hit_t h;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		new_scan <= it.new_scan;
		new_run <= it.new_run;
		data_byte <= it.data;
		byte_address <= it.addr;
		do @(posedge clk); while (!in_ready);
		scan_predict(it, taken, has_hit, h);
		if (chk == CHK_HIT) begin
			hits_due.insert(hits_due.size(), typed);
		end else if (chk == CHK_PRED && has_hit) begin
			hits_due.insert(hits_due.size(), h);
		end
		work_since_idle = 1'b1;
		bytes_sent++;
	endtask

	// Run-start items keep the block busy long after acceptance, so pause before any write.
	task automatic wait_idle();
		if (!work_since_idle) begin
			return;
		end
		in_valid <= 1'b0;
		while (hits_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		work_since_idle = 1'b0;
	endtask

	task automatic write_reg(input cfg_reg_t id, input logic [63:0] value);
		cfg_write <= 1'b1;
		cfg_index <= id;
		cfg_data <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
		case (id)
			CFG_PATTERN_LOW: cfg_live.pat_lo = value;
			CFG_PATTERN_HIGH: cfg_live.pat_hi = value;
			CFG_MASK_LOW: cfg_live.msk_lo = value;
			CFG_MASK_HIGH: cfg_live.msk_hi = value;
			CFG_LENGTH: cfg_live.plen = value[4:0];
			CFG_ALIGNMENT: cfg_live.align = value[15:0];
			CFG_HIT_LIMIT: cfg_live.limit = value[15:0];
			CFG_CAPACITY: cfg_live.cap = value[15:0];
			default: ;
		endcase
	endtask

	task automatic apply_config(input scan_cfg_t c);
		write_reg(CFG_PATTERN_LOW, c.pat_lo);
		write_reg(CFG_PATTERN_HIGH, c.pat_hi);
		write_reg(CFG_MASK_LOW, c.msk_lo);
		write_reg(CFG_MASK_HIGH, c.msk_hi);
		write_reg(CFG_LENGTH, 64'(c.plen));
		write_reg(CFG_ALIGNMENT, 64'(c.align));
		write_reg(CFG_HIT_LIMIT, 64'(c.limit));
		write_reg(CFG_CAPACITY, 64'(c.cap));
	endtask

	function automatic logic [7:0] random_mask_byte();
		case ($urandom_range(0, 4))
			0: return 8'h00;
			1, 2: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic scan_cfg_t pick_config(int phase);
		scan_cfg_t c;
		int k;
		c.pat_lo = {$urandom, $urandom};
		c.pat_hi = {$urandom, $urandom};
		for (k = 0; k < 8; k++) begin
			c.msk_lo[8*k +: 8] = random_mask_byte();
			c.msk_hi[8*k +: 8] = random_mask_byte();
		end
		case ($urandom_range(0, 9))
			0: c.plen = 5'd0;
			1: c.plen = 5'd16;
			2: c.plen = 5'($urandom_range(17, 31));
			default: c.plen = 5'($urandom_range(1, 6));
		endcase
		case ($urandom_range(0, 9))
			0: c.align = 16'd0;
			1: c.align = 16'hFFFF;
			2: c.align = 16'd1;
			default: c.align = 16'($urandom_range(1, 8));
		endcase
		case ($urandom_range(0, 5))
			0, 1: c.limit = 16'd0;
			2: c.limit = 16'hFFFF;
			default: c.limit = 16'($urandom_range(1, 12));
		endcase
		case ($urandom_range(0, 5))
			0, 1: c.cap = 16'hFFFF;
			default: c.cap = 16'($urandom_range(1, 12));
		endcase
		// The first setting forces the widest alignment, and both of the first two the smallest capacity.
		if (phase == 0) begin
			c.align = 16'hFFFF;
			c.cap = 16'd1;
			c.limit = 16'd0;
		end else if (phase == 1) begin
			c.align = 16'd2;
			c.cap = 16'd1;
			c.limit = 16'hFFFF;
		end
		return c;
	endfunction

	// One run of consecutive bytes, with copies of the pattern planted at aligned starts.
	task automatic send_run();
		logic [7:0] run_bytes [64];
		logic [63:0] start, r;
		logic [7:0] m;
		int unsigned align_eff, len_eff, run_len, ph, o, p, i, sel;
		scan_in_t it;
		bit taken;
		align_eff = eff_align();
		len_eff = eff_len();
		sel = $urandom_range(0, 9);
		r = {$urandom, $urandom};
		if (sel == 1) begin
			r = ~64'd0 - 64'($urandom_range(0, 40));
		end
		start = (sel == 0) ? r : r - (r % 64'(align_eff));
		run_len = $urandom_range(1, len_eff + 24);
		for (i = 0; i < run_len; i++) begin
			run_bytes[i] = 8'($urandom);
		end
		ph = int'(start % 64'(align_eff));
		o = (ph == 0) ? 0 : align_eff - ph;
		while (o + len_eff <= run_len) begin
			if ($urandom_range(0, 1) == 1) begin
				for (p = 0; p < len_eff; p++) begin
					m = cfg_byte(cfg_live.msk_lo, cfg_live.msk_hi, p);
					run_bytes[o+p] = (cfg_byte(cfg_live.pat_lo, cfg_live.pat_hi, p) & m)
						| (8'($urandom) & ~m);
				end
			end
			o += align_eff;
		end
		if ($urandom_range(0, 3) == 0) begin
			run_bytes[$urandom_range(0, run_len - 1)] ^= 8'(1 << $urandom_range(0, 7));
		end
		for (i = 0; i < run_len; i++) begin
			if (i == 0) begin
				it.new_scan = ($urandom_range(0, 9) < 3);
				it.new_run = it.new_scan ? 1'($urandom_range(0, 1)) : 1'b1;
			end else begin
				it.new_scan = ($urandom_range(0, 79) == 0);
				it.new_run = ($urandom_range(0, 39) == 0);
			end
			it.data = run_bytes[i];
			it.addr = ($urandom_range(0, 49) == 0) ? {$urandom, $urandom} : start + 64'(i);
			send_item(it, CHK_PRED, '0, taken);
			scanned_random++;
			if (!taken) begin
				ignored_random++;
			end
		end
	endtask

	function automatic plan_row_t reg_row(cfg_reg_t id, logic [63:0] value);
		plan_row_t r;
		r = '{ROW_REG, id, value, '0, CHK_NONE, '0};
		return r;
	endfunction

	function automatic plan_row_t byte_row(logic ns, logic nr, logic [7:0] d, logic [63:0] a,
			check_t chk = CHK_PRED, scan_hit_t hit = '0);
		plan_row_t r;
		r = '{ROW_ITEM, CFG_PATTERN_LOW, 64'd0, scan_in_t'{ns, nr, d, a}, chk, hit};
		return r;
	endfunction

	initial begin : result_sink
		int left;
		bit lvl;
		left = 0;
		lvl = 1'b1;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (left == 0) begin
				lvl = !lvl;
				if (lvl) begin
					left = $urandom_range(1, 30);
				end else begin
					left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
				end
			end
			left--;
			out_ready <= lvl || calm;
		end
	end

	always @(posedge clk) begin : result_check
		scan_hit_t want;
		if (arst_n && out_valid && out_ready) begin
			if (hits_due.size() == 0) begin
				report_mismatch($sformatf("unexpected result, hit_start %h", hit_start));
			end else begin
				want = hits_due.pop_front();
				if (want.kind == KIND_OVERFLOW) begin
					overflows_seen++;
				end else begin
					matches_seen++;
				end
				if (hit_start !== want.addr) begin
					report_mismatch($sformatf("hit_start %h, expected %h", hit_start, want.addr));
				end
				if (hit_kind !== want.kind) begin
					report_mismatch($sformatf("hit_kind %b, expected %b", hit_kind, want.kind));
				end
				if (hit_index !== want.index) begin
					report_mismatch($sformatf("hit_index %0d, expected %0d", hit_index, want.index));
				end
				if (scan_stopped !== want.stopped) begin
					report_mismatch($sformatf("scan_stopped %b, expected %b", scan_stopped,
						want.stopped));
				end
			end
		end
	end

	initial begin : stimulus
		int unsigned p;
		int phase;
		bit taken;
		arst_n <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= CFG_PATTERN_LOW;
		cfg_data <= 64'd0;
		in_valid <= 1'b0;
		new_scan <= 1'b0;
		new_run <= 1'b0;
		data_byte <= 8'h00;
		byte_address <= 64'd0;
		calm = 1'b0;

		// After reset the mask is all wildcard, so every byte is a hit at its own address.
		plan_add(byte_row(1, 0, 8'h00, 64'd0, CHK_HIT,
			scan_hit_t'{64'd0, KIND_MATCH, 16'd1, 1'b0}));
		plan_add(byte_row(0, 0, 8'hFF, ~64'd0, CHK_HIT,
			scan_hit_t'{~64'd0, KIND_MATCH, 16'd2, 1'b0}));
		// A zero hit limit falls back to the capacity, which is already met.
		plan_add(reg_row(CFG_CAPACITY, 64'd2));
		plan_add(byte_row(0, 1, 8'h5A, 64'd1, CHK_NONE));
		plan_add(byte_row(0, 0, 8'hA5, 64'd2, CHK_NONE));
		// Capacity below the limit: the third match overflows and stops the scan.
		plan_add(reg_row(CFG_HIT_LIMIT, 64'd3));
		plan_add(byte_row(1, 0, 8'h11, 64'd100, CHK_HIT,
			scan_hit_t'{64'd100, KIND_MATCH, 16'd1, 1'b0}));
		plan_add(byte_row(0, 0, 8'h22, 64'd101, CHK_HIT,
			scan_hit_t'{64'd101, KIND_MATCH, 16'd2, 1'b0}));
		plan_add(byte_row(0, 0, 8'h33, 64'd102, CHK_HIT,
			scan_hit_t'{64'd0, KIND_OVERFLOW, 16'd2, 1'b1}));
		// Zero length and zero alignment both act as one.
		plan_add(reg_row(CFG_HIT_LIMIT, 64'hFFFF));
		plan_add(reg_row(CFG_CAPACITY, 64'hFFFF));
		plan_add(reg_row(CFG_LENGTH, 64'd0));
		plan_add(reg_row(CFG_ALIGNMENT, 64'd0));
		plan_add(reg_row(CFG_PATTERN_LOW, 64'hAB));
		plan_add(reg_row(CFG_MASK_LOW, 64'hFF));
		plan_add(byte_row(1, 0, 8'hAB, 64'h40, CHK_HIT,
			scan_hit_t'{64'h40, KIND_MATCH, 16'd1, 1'b0}));
		plan_add(byte_row(0, 0, 8'hAC, 64'h41, CHK_NONE));
		plan_add(byte_row(0, 1, 8'hAB, 64'h8000_0000_0000_0000, CHK_HIT,
			scan_hit_t'{64'h8000_0000_0000_0000, KIND_MATCH, 16'd2, 1'b0}));
		// An oversized length is cut to the full window; the run wraps the address space.
		plan_add(reg_row(CFG_LENGTH, 64'd31));
		plan_add(reg_row(CFG_ALIGNMENT, 64'd4));
		plan_add(reg_row(CFG_PATTERN_LOW, 64'h0706_0504_0302_0100));
		plan_add(reg_row(CFG_PATTERN_HIGH, 64'h0F0E_0D0C_0B0A_0908));
		plan_add(reg_row(CFG_MASK_LOW, ~64'd0));
		plan_add(reg_row(CFG_MASK_HIGH, 64'hFF00_FFFF_F0FF_FFFF));
		for (p = 0; p < 16; p++) begin
			plan_add(byte_row(0, p == 0,
				(p == 11) ? 8'h0E : (p == 14) ? 8'hC3 : 8'(p),
				64'hFFFF_FFFF_FFFF_FFFC + 64'(p)));
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[i]) begin
			if (directed_plan[i].kind == ROW_REG) begin
				wait_idle();
				write_reg(directed_plan[i].reg_id, directed_plan[i].value);
			end else begin
				send_item(directed_plan[i].item, directed_plan[i].chk, directed_plan[i].hit, taken);
			end
		end

		phase = 0;
		while (scanned_random < RANDOM_BYTES) begin
			wait_idle();
			calm = ($urandom_range(0, 4) == 0);
			apply_config(pick_config(phase));
			repeat ($urandom_range(3, 8)) send_run();
			phase++;
		end
		calm = 1'b0;
		wait_idle();

		$display("Sent %0d bytes (%0d directed rows, %0d random register settings).",
			bytes_sent, directed_plan.size(), phase);
		$display("Checked %0d match results and %0d overflow results; %0d random bytes fell on a stopped scan.",
			matches_seen, overflows_seen, ignored_random);
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

FILE: filelist.f
hdl/mbps_pkg.sv
hdl/mbps_mod_unit.sv
hdl/mbps_cell.sv
hdl/masked_byte_pattern_scan.sv
hdl/mbps_checker.sv
tb/masked_byte_pattern_scan_test.sv
